@@ rtl/ple_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes and types of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = 7;
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int ST_W     = 3;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [ST_W-1:0]  status_t;

	localparam cmd_t CMD_INS_FRONT = 3'd0;
	localparam cmd_t CMD_INS_END   = 3'd1;
	localparam cmd_t CMD_INS_POS   = 3'd2;
	localparam cmd_t CMD_DEL_FRONT = 3'd3;
	localparam cmd_t CMD_DEL_END   = 3'd4;
	localparam cmd_t CMD_DEL_POS   = 3'd5;
	localparam cmd_t CMD_READ      = 3'd6;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_FULL    = 3'd1;
	localparam status_t ST_EMPTY   = 3'd2;
	localparam status_t ST_INVALID = 3'd3;
	localparam status_t ST_RANGE   = 3'd4;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

endpackage
`default_nettype wire

@@ rtl/ple_cmd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cmd_if
// Command channel: one item carries a command, a value and a position.
// ----------------------------------------------------------------------------
interface ple_cmd_if
	import ple_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] value;
	logic [CNT_W-1:0]         position;

	modport source (output valid, cmd, value, position, input ready);
	modport sink (input valid, cmd, value, position, output ready);
endinterface
`default_nettype wire

@@ rtl/ple_res_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_res_if
// Result channel: status, read-out element, last mark and entry count.
// ----------------------------------------------------------------------------
interface ple_res_if
	import ple_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] element;
	logic                     element_valid;
	logic                     last;
	logic [CNT_W-1:0]         entries;

	modport source (output valid, status, element, element_valid, last, entries,
		input ready);
	modport sink (input valid, status, element, element_valid, last, entries,
		output ready);
endinterface
`default_nettype wire

@@ rtl/ple_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_store
// Entry memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ple_store
	import ple_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic [DATA_W-1:0]      rdata
);

	logic [DATA_W-1:0] slots [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			slots[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= slots[req.raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/ple_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer: decodes a command, walks the shift or read-out through the
// memory one entry per step, and holds the result register.
// ----------------------------------------------------------------------------
module ple_ctrl
	import ple_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	ple_cmd_if.sink           cmd_ch,
	ple_res_if.source         res_ch,
	output mem_req_t          mem_req,
	input  wire logic [DATA_W-1:0] rdata
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_MOVE    = 5'b00010,
		S_RESULT  = 5'b00100,
		S_RD_ADDR = 5'b01000,
		S_RD_DATA = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  stop_q;
	logic [IDX_W-1:0]  src_q;
	logic              ins_q;
	logic              more_q;
	logic              pend_q;
	logic [DATA_W-1:0] val_q;
	status_t           status_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [DATA_W-1:0] out_elem_q;
	logic              out_ev_q;
	logic              out_last_q;
	logic [CNT_W-1:0]  out_entries_q;

	status_t           st;
	logic              do_ins;
	logic              do_del;
	logic              do_rd;
	logic [CNT_W-1:0]  idx_n;
	logic [CNT_W-1:0]  idx_p1;
	logic              full;
	logic              empty;
	logic              accept;
	logic              out_free;
	logic              out_load;
	logic              rd_last;

	assign full     = fill_q >= CNT_W'(CAPACITY);
	assign empty    = fill_q == '0;
	assign accept   = cmd_ch.valid && cmd_ch.ready;
	assign out_free = !out_valid_q || res_ch.ready;
	assign out_load = ((state_q == S_RESULT) || (state_q == S_RD_DATA)) && out_free;
	assign idx_p1   = idx_n + CNT_W'(1);
	assign rd_last  = (CNT_W'(j_q) + CNT_W'(1)) == fill_q;

	assign cmd_ch.ready         = state_q == S_IDLE;
	assign res_ch.valid         = out_valid_q;
	assign res_ch.status        = out_status_q;
	assign res_ch.element       = out_elem_q;
	assign res_ch.element_valid = out_ev_q;
	assign res_ch.last          = out_last_q;
	assign res_ch.entries       = out_entries_q;

	always_comb begin
		st     = ST_OK;
		do_ins = 1'b0;
		do_del = 1'b0;
		do_rd  = 1'b0;
		idx_n  = '0;
		case (cmd_ch.cmd)
			CMD_INS_FRONT: begin
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			CMD_INS_END: begin
				idx_n = fill_q;
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			CMD_INS_POS: begin
				idx_n = cmd_ch.position - CNT_W'(1);
				if (cmd_ch.position == '0) st = ST_INVALID;
				else if (full) st = ST_FULL;
				else if ({1'b0, cmd_ch.position} > ({1'b0, fill_q} + 8'd1)) st = ST_RANGE;
				else do_ins = 1'b1;
			end
			CMD_DEL_FRONT: begin
				if (empty) st = ST_EMPTY;
				else do_del = 1'b1;
			end
			CMD_DEL_END: begin
				idx_n = fill_q - CNT_W'(1);
				if (empty) st = ST_EMPTY;
				else do_del = 1'b1;
			end
			CMD_DEL_POS: begin
				idx_n = cmd_ch.position - CNT_W'(1);
				if (empty) st = ST_EMPTY;
				else if (cmd_ch.position == '0) st = ST_INVALID;
				else if (cmd_ch.position > fill_q) st = ST_RANGE;
				else do_del = 1'b1;
			end
			CMD_READ: begin
				if (empty) st = ST_EMPTY;
				else do_rd = 1'b1;
			end
			default: st = ST_OK;
		endcase
	end

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_MOVE: begin
				mem_req.re    = more_q;
				mem_req.raddr = j_q;
				if (pend_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = ins_q ? src_q + IDX_W'(1) : src_q - IDX_W'(1);
					mem_req.wdata = rdata;
				end else if (!more_q && ins_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = stop_q;
					mem_req.wdata = val_q;
				end
			end
			S_RD_ADDR: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = j_q;
			end
			default: mem_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			more_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && res_ch.ready && !out_load) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q    <= cmd_ch.value;
						status_q <= st;
						pend_q   <= 1'b0;
						if (do_ins) begin
							state_q <= S_MOVE;
							ins_q   <= 1'b1;
							more_q  <= idx_n < fill_q;
							j_q     <= IDX_W'(fill_q - CNT_W'(1));
							stop_q  <= IDX_W'(idx_n);
						end else if (do_del) begin
							state_q <= S_MOVE;
							ins_q   <= 1'b0;
							more_q  <= idx_p1 < fill_q;
							j_q     <= IDX_W'(idx_p1);
							stop_q  <= IDX_W'(fill_q - CNT_W'(1));
						end else if (do_rd) begin
							state_q <= S_RD_ADDR;
							j_q     <= '0;
						end else begin
							state_q <= S_RESULT;
						end
					end
				end
				S_MOVE: begin
					if (more_q) begin
						src_q  <= j_q;
						pend_q <= 1'b1;
						if (j_q == stop_q) more_q <= 1'b0;
						else j_q <= ins_q ? j_q - IDX_W'(1) : j_q + IDX_W'(1);
					end else begin
						pend_q <= 1'b0;
					end
					if (!more_q && !pend_q) begin
						fill_q  <= ins_q ? fill_q + CNT_W'(1) : fill_q - CNT_W'(1);
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= status_q;
						out_elem_q    <= '0;
						out_ev_q      <= 1'b0;
						out_last_q    <= 1'b1;
						out_entries_q <= fill_q;
						state_q       <= S_IDLE;
					end
				end
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= ST_OK;
						out_elem_q    <= rdata;
						out_ev_q      <= 1'b1;
						out_last_q    <= rd_last;
						out_entries_q <= fill_q;
						if (rd_last) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + IDX_W'(1);
							state_q <= S_RD_ADDR;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/positional_list_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit entries with positional insert,
// delete and full read-out.
// ----------------------------------------------------------------------------
// The list lives in a single-port-write, registered-read memory, and one
// sequencer steps every command through it, so the block takes one command
// at a time and holds cmd_ch.ready low until that command's results are
// queued. An insert or delete moves k entries, where k is the number of
// entries behind the target position, one entry per cycle through the
// memory port, and then passes to the result state. Error results and
// unused command codes move nothing and go straight to the result state. A
// read-out emits one result per entry (address, then registered data), with
// last set on the final entry; an empty list gives a single empty result. A
// stalled result channel holds the sequencer in its result states. No
// clearing pass is run after reset; entries are only read below the fill
// count.
// ----------------------------------------------------------------------------
module positional_list_engine
	import ple_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ple_cmd_if.sink   cmd_ch,
	ple_res_if.source res_ch
);

	mem_req_t          mem_req;
	logic [DATA_W-1:0] rdata;

	ple_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_ch),
		.res_ch  (res_ch),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	ple_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	a_entries_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> res_ch.entries <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_elem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.element_valid |-> res_ch.status == ST_OK)
		else $error("read-out element with error status");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && !res_ch.element_valid |-> res_ch.last)
		else $error("non-element result not marked last");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ch.valid && cmd_ch.ready |=> !cmd_ch.ready)
		else $error("command taken while previous one in progress");

	a_port_split: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we && mem_req.re |-> mem_req.waddr != mem_req.raddr)
		else $error("shift reads and writes the same entry");

endmodule
`default_nettype wire

@@ sim/positional_list_engine_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_test
// Self-checking testbench of the positional list engine. A driver feeds
// commands from a backlog with random gaps, and a monitor takes results with
// random stalls. A shadow copy of the list predicts every result, and the
// monitor compares each result field by field in order. A directed opening
// covers empty, invalid, out-of-range and full cases. Random phases then grow,
// shrink and churn the list with well-formed commands plus some noise.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
	import ple_pkg::*;

	localparam int   MAX_RESULTS    = 64;
	localparam int   TOTAL_OPS      = 210;
	localparam int   WATCHDOG_LIMIT = 3000;
	localparam int   HOLD_CYCLES    = 150;
	localparam cmd_t CMD_UNUSED     = 3'd7;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]         position;
		logic                     pause;
	} list_op_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] element;
		logic                     element_valid;
		logic                     last;
		logic [CNT_W-1:0]         entries;
	} list_result_t;

	typedef struct packed {
		logic [CAPACITY-1:0][DATA_W-1:0] slot;
		logic [CNT_W-1:0]                fill;
	} list_state_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ple_cmd_if cmd_ch();
	ple_res_if res_ch();

	positional_list_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	always #10 clk = ~clk;

	list_op_t     cmd_backlog[$];
	list_result_t due_results[$];
	list_state_t  planned_list;
	list_state_t  tracked_list;

	int ops_total     = 0;
	int sent_total    = 0;
	int checked_total = 0;
	int fail_cnt      = 0;
	int full_rejects  = 0;
	int readouts      = 0;
	int peak_fill     = 0;
	int src_wait, src_calm, snk_wait, snk_calm;
	int hold_left, next_hold_at, idle_cycles;
	logic long_hold;

	function automatic int list_apply(inout list_state_t s, input list_op_t op,
		output list_result_t r [MAX_RESULTS]);
		status_t st;
		int      f;
		int      at;
		logic    grow;
		logic    shrink;
		st     = ST_OK;
		f      = int'(s.fill);
		at     = 0;
		grow   = 1'b0;
		shrink = 1'b0;
		case (op.cmd)
			CMD_INS_FRONT: begin
				if (f >= CAPACITY) st = ST_FULL;
				else grow = 1'b1;
			end
			CMD_INS_END: begin
				if (f >= CAPACITY) st = ST_FULL;
				else begin
					grow = 1'b1;
					at   = f;
				end
			end
			CMD_INS_POS: begin
				if (op.position == 0) st = ST_INVALID;
				else if (f >= CAPACITY) st = ST_FULL;
				else if (int'(op.position) > f + 1) st = ST_RANGE;
				else begin
					grow = 1'b1;
					at   = int'(op.position) - 1;
				end
			end
			CMD_DEL_FRONT: begin
				if (f == 0) st = ST_EMPTY;
				else shrink = 1'b1;
			end
			CMD_DEL_END: begin
				if (f == 0) st = ST_EMPTY;
				else begin
					shrink = 1'b1;
					at     = f - 1;
				end
			end
			CMD_DEL_POS: begin
				if (f == 0) st = ST_EMPTY;
				else if (op.position == 0) st = ST_INVALID;
				else if (int'(op.position) > f) st = ST_RANGE;
				else begin
					shrink = 1'b1;
					at     = int'(op.position) - 1;
				end
			end
			CMD_READ: begin
				if (f == 0) st = ST_EMPTY;
				else begin
					for (int i = 0; i < f; i++)
						r[i] = '{ST_OK, s.slot[i], 1'b1, (i == f - 1), s.fill};
					return f;
				end
			end
			default: ;
		endcase
		if (grow) begin
			for (int k = f; k > at; k--)
				s.slot[k] = s.slot[k-1];
			s.slot[at] = op.value;
			s.fill     = s.fill + 1'b1;
		end
		if (shrink) begin
			for (int k = at; k < f - 1; k++)
				s.slot[k] = s.slot[k+1];
			s.fill = s.fill - 1'b1;
		end
		r[0] = '{st, '0, 1'b0, 1'b1, s.fill};
		return 1;
	endfunction

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return {1'b0, {(DATA_W-1){1'b1}}};
			1: return {1'b1, {(DATA_W-1){1'b0}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_op(input cmd_t c, input logic signed [DATA_W-1:0] v, input int p);
		list_op_t     op;
		list_result_t scratch [MAX_RESULTS];
		op = '{cmd: c, value: v, position: p[CNT_W-1:0], pause: 1'b0};
		void'(list_apply(planned_list, op, scratch));
		cmd_backlog.push_back(op);
		ops_total++;
	endtask

	task automatic push_insert();
		int f;
		f = int'(planned_list.fill);
		case ($urandom_range(0, 2))
			0: push_op(CMD_INS_FRONT, rand_value(), $urandom_range(0, 127));
			1: push_op(CMD_INS_END, rand_value(), $urandom_range(0, 127));
			default: push_op(CMD_INS_POS, rand_value(), $urandom_range(1, f + 1));
		endcase
	endtask

	task automatic push_delete();
		int f;
		f = int'(planned_list.fill);
		case ($urandom_range(0, 2))
			0: push_op(CMD_DEL_FRONT, rand_value(), $urandom_range(0, 127));
			1: push_op(CMD_DEL_END, rand_value(), $urandom_range(0, 127));
			default: push_op(CMD_DEL_POS, rand_value(), $urandom_range(1, (f == 0) ? 1 : f));
		endcase
	endtask

	task automatic push_noise();
		int f;
		f = int'(planned_list.fill);
		if ($urandom_range(0, 1) == 0)
			push_op(cmd_t'($urandom_range(0, 7)), rand_value(), $urandom_range(0, 127));
		else
			push_op(cmd_t'($urandom_range(0, 7)), rand_value(), f + $urandom_range(0, 2));
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		list_op_t     op;
		list_result_t rbuf [MAX_RESULTS];
		int           n;
		if (!arst_n) begin
			cmd_ch.valid    <= 1'b0;
			cmd_ch.cmd      <= CMD_READ;
			cmd_ch.value    <= '0;
			cmd_ch.position <= '0;
			src_wait        <= 0;
			src_calm        = 0;
			tracked_list    = '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				op = '{cmd: cmd_ch.cmd, value: cmd_ch.value, position: cmd_ch.position,
					pause: 1'b0};
				n = list_apply(tracked_list, op, rbuf);
				for (int i = 0; i < n; i++) begin
					due_results.push_back(rbuf[i]);
					if (rbuf[i].status == ST_FULL) full_rejects++;
				end
				if (op.cmd == CMD_READ) readouts++;
				if (int'(tracked_list.fill) > peak_fill) peak_fill = int'(tracked_list.fill);
				sent_total++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (src_wait != 0) begin
					src_wait     <= src_wait - 1;
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog.size() == 0) begin
					cmd_ch.valid <= 1'b0;
				end else if (cmd_backlog[0].pause) begin
					cmd_ch.valid <= 1'b0;
					if (due_results.size() == 0) void'(cmd_backlog.pop_front());
				end else begin
					op = cmd_backlog.pop_front();
					cmd_ch.cmd      <= op.cmd;
					cmd_ch.value    <= op.value;
					cmd_ch.position <= op.position;
					cmd_ch.valid    <= 1'b1;
					src_wait        <= draw_gap(src_calm);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		list_result_t got;
		list_result_t want;
		int           w;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			snk_wait     <= 0;
			snk_calm     = 0;
		end else begin
			w = snk_wait;
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.status, res_ch.element, res_ch.element_valid, res_ch.last,
					res_ch.entries};
				checked_total++;
				if (due_results.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("Unexpected result: status %0d element %0d entries %0d",
							got.status, got.element, got.entries);
				end else begin
					want = due_results.pop_front();
					if (got.status !== want.status || got.element !== want.element ||
						got.element_valid !== want.element_valid ||
						got.last !== want.last || got.entries !== want.entries) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display("Mismatch at result %0d:", checked_total);
							$display("    expected status %0d element %0d valid %0b",
								want.status, want.element, want.element_valid);
							$display("    expected last %0b entries %0d",
								want.last, want.entries);
							$display("    actual status %0d element %0d valid %0b",
								got.status, got.element, got.element_valid);
							$display("    actual last %0b entries %0d",
								got.last, got.entries);
						end
					end
				end
				w = draw_gap(snk_calm);
			end
			if (long_hold) begin
				res_ch.ready <= 1'b0;
				snk_wait     <= w;
			end else if (w != 0) begin
				res_ch.ready <= 1'b0;
				snk_wait     <= w - 1;
			end else begin
				res_ch.ready <= 1'b1;
				snk_wait     <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : hold_off
		if (!arst_n) begin
			long_hold    <= 1'b0;
			hold_left    <= 0;
			next_hold_at <= 60;
		end else if (long_hold) begin
			if (hold_left == 0) long_hold <= 1'b0;
			else hold_left <= hold_left - 1;
		end else if (checked_total >= next_hold_at) begin
			long_hold    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + 350;
		end
	end

	always @(posedge clk or negedge arst_n) begin : watchdog
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
				idle_cycles, due_results.size());
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		mix_t mix;
		int   r;
		bit   paused;
		planned_list    = '0;
		paused          = 1'b0;

		push_op(CMD_READ, '0, 0);
		push_op(CMD_DEL_FRONT, '0, 0);
		push_op(CMD_DEL_END, '0, 127);
		push_op(CMD_DEL_POS, '0, 0);
		push_op(CMD_INS_POS, 32'sd5, 0);
		push_op(CMD_INS_POS, 32'sd6, 2);
		push_op(CMD_INS_POS, {1'b0, {(DATA_W-1){1'b1}}}, 1);
		push_op(CMD_INS_FRONT, {1'b1, {(DATA_W-1){1'b0}}}, 0);
		push_op(CMD_INS_END, '0, 127);
		push_op(CMD_INS_POS, '1, 4);
		push_op(CMD_INS_POS, $urandom, 2);
		push_op(CMD_READ, '0, 127);
		push_op(CMD_DEL_POS, '0, 0);
		push_op(CMD_DEL_POS, '0, 6);
		push_op(CMD_DEL_POS, '0, 127);
		push_op(CMD_INS_POS, $urandom, 127);
		push_op(CMD_UNUSED, '1, 127);
		push_op(CMD_DEL_POS, '0, 3);
		push_op(CMD_DEL_FRONT, '0, 0);
		push_op(CMD_DEL_END, '0, 0);
		push_op(CMD_DEL_POS, '0, 2);
		push_op(CMD_READ, '0, 0);
		push_op(CMD_DEL_POS, '0, 1);
		push_op(CMD_READ, '0, 0);

		while (planned_list.fill < CAPACITY) push_insert();
		push_op(CMD_INS_FRONT, $urandom, 0);
		push_op(CMD_INS_END, $urandom, 0);
		push_op(CMD_INS_POS, $urandom, 0);
		push_op(CMD_INS_POS, $urandom, 1);
		push_op(CMD_INS_POS, $urandom, 127);
		push_op(CMD_READ, '0, 0);

		while (ops_total < TOTAL_OPS) begin
			mix = mix_t'($urandom_range(0, 2));
			repeat ($urandom_range(10, 30)) begin
				if (ops_total < TOTAL_OPS) begin
					r = $urandom_range(0, 99);
					case (mix)
						MIX_GROW: begin
							if (r < 65) push_insert();
							else if (r < 80) push_delete();
							else if (r < 90) push_op(CMD_READ, rand_value(), $urandom_range(0, 127));
							else push_noise();
						end
						MIX_SHRINK: begin
							if (r < 65) push_delete();
							else if (r < 80) push_insert();
							else if (r < 90) push_op(CMD_READ, rand_value(), $urandom_range(0, 127));
							else push_noise();
						end
						default: begin
							if (r < 40) push_insert();
							else if (r < 75) push_delete();
							else if (r < 88) push_op(CMD_READ, rand_value(), $urandom_range(0, 127));
							else push_noise();
						end
					endcase
				end
			end
			if (!paused && ops_total >= 130) begin
				cmd_backlog.push_back('{cmd: CMD_READ, value: '0, position: '0, pause: 1'b1});
				paused = 1'b1;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_total < ops_total) @(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d commands, %0d results, %0d read-outs, %0d full rejects, peak %0d/%0d",
			sent_total, checked_total, readouts, full_rejects, peak_fill, CAPACITY);
		$display("Mismatches or stray results: %0d", fail_cnt);
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
